### hdl/calendar_date_time_difference_defines.svh
// assertion macros for the date difference block
`ifndef CALENDAR_DATE_TIME_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DATE_TIME_DIFFERENCE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define CDTD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define CDTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDTD_ASSERT(lbl, clk, rst, prop, msg)
`define CDTD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/cdtd_pkg.sv
package cdtd_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int SOD_W    = 17;
   localparam int DAYS_W   = 23;
   localparam int SECS_W   = 40;
   localparam int DOY_W    = 9;
   localparam int MOD400_W = 9;

   localparam logic [YEAR_W-1:0]   YEAR_LIMIT     = 14'd9999;
   localparam logic [MOD400_W-1:0] CYCLE_LAST     = 9'd399;
   localparam logic [DOY_W-1:0]    DAYS_COMMON    = 9'd365;
   localparam logic [DOY_W-1:0]    DAYS_LEAP      = 9'd366;
   localparam logic signed [17:0]  SECONDS_PER_DAY = 18'sd86400;
   // floor(x / 25) = (x * 1311) >> 15 for x up to 624
   localparam logic [10:0]         RECIP_25       = 11'd1311;

   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [SOD_W-1:0]   sod_type;

   // leap year from the year's position in the 400 year cycle
   function automatic logic leap_of(input logic [MOD400_W-1:0] m400);
      return (m400[1:0] == 2'd0) && (m400 != 9'd100) && (m400 != 9'd200) &&
             (m400 != 9'd300);
   endfunction

   function automatic logic [DOY_W-1:0] days_before(input month_type m);
      logic [DOY_W-1:0] n;
      unique case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // zero based day within the year
   function automatic logic [DOY_W-1:0] day_of_year(input month_type m, input day_type d,
                                                    input logic leap);
      logic [DOY_W-1:0] n;
      n = days_before(m) + DOY_W'(leap && (m > 4'd2)) + DOY_W'(d) - 9'd1;
      return n;
   endfunction

endpackage

### hdl/cdtd_req_if.sv
interface cdtd_req_if;
   logic                valid;
   logic                ready;
   cdtd_pkg::year_type  first_year;
   cdtd_pkg::month_type first_month;
   cdtd_pkg::day_type   first_day;
   cdtd_pkg::sod_type   first_second_of_day;
   cdtd_pkg::year_type  second_year;
   cdtd_pkg::month_type second_month;
   cdtd_pkg::day_type   second_day;
   cdtd_pkg::sod_type   second_second_of_day;

   modport source (
      output valid, first_year, first_month, first_day, first_second_of_day,
             second_year, second_month, second_day, second_second_of_day,
      input  ready
   );
   modport sink (
      input  valid, first_year, first_month, first_day, first_second_of_day,
             second_year, second_month, second_day, second_second_of_day,
      output ready
   );
endinterface

### hdl/cdtd_rsp_if.sv
interface cdtd_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [cdtd_pkg::DAYS_W-1:0]       day_difference;
   logic signed [cdtd_pkg::SECS_W-1:0]       second_difference;
   logic                                     invalid;

   modport source (
      output valid, day_difference, second_difference, invalid,
      input  ready
   );
   modport sink (
      input  valid, day_difference, second_difference, invalid,
      output ready
   );
endinterface

### hdl/calendar_date_time_difference.sv
// channel   | dir | port   | contents
// request   | in  | req_if | two dates (year, month, day) and two second-of-day counts
// result    | out | rsp_if | signed day and second differences, invalid flag
//
// a request steps through the sequencer from acceptance to its result, one whole year
// per cycle, counted through a single shared adder; an invalid request goes from the
// check step straight to the finish step. ready returns with the result, so a new request
// is taken only once the one before it has been written to the result register.
// reset is synchronous; it idles the sequencer and empties the result register.
// a finished result waits in the result register and the next request may be taken
// meanwhile; that request stalls at its last step until the register is free.
`include "calendar_date_time_difference_defines.svh"

module calendar_date_time_difference (
   input logic          clock,
   input logic          reset,
   cdtd_req_if.sink     req_if,
   cdtd_rsp_if.source   rsp_if
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_QUOT   = 4'd2;
   localparam logic [3:0] S_MOD    = 4'd3;
   localparam logic [3:0] S_DOYA   = 4'd4;
   localparam logic [3:0] S_YEARS  = 4'd5;
   localparam logic [3:0] S_DOYB   = 4'd6;
   localparam logic [3:0] S_NEG    = 4'd7;
   localparam logic [3:0] S_MUL    = 4'd8;
   localparam logic [3:0] S_FINISH = 4'd9;

   logic [3:0] state_ff, state_in;

   // request capture
   cdtd_pkg::year_type  y1_ff, y2_ff;
   cdtd_pkg::month_type m1_ff, m2_ff;
   cdtd_pkg::day_type   d1_ff, d2_ff;
   cdtd_pkg::sod_type   s1_ff, s2_ff;

   // ordered dates
   cdtd_pkg::year_type  year_ff, year_in;
   cdtd_pkg::year_type  yb_ff, yb_in;
   cdtd_pkg::month_type ma_ff, ma_in, mb_ff, mb_in;
   cdtd_pkg::day_type   da_ff, da_in, db_ff, db_in;
   logic                neg_ff, neg_in;
   logic                bad_ff, bad_in;

   logic [5:0]                        quot_ff, quot_in;
   logic [cdtd_pkg::MOD400_W-1:0]     mod_ff, mod_in;
   logic signed [cdtd_pkg::DAYS_W-1:0] acc_ff, acc_in;
   logic signed [cdtd_pkg::SECS_W-1:0] prod_ff, prod_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [cdtd_pkg::DAYS_W-1:0] rsp_days_ff, rsp_days_in;
   logic signed [cdtd_pkg::SECS_W-1:0] rsp_secs_ff, rsp_secs_in;
   logic                               rsp_bad_ff, rsp_bad_in;

   logic                               accept;
   logic                               out_free;
   logic                               bad_now;
   logic                               swap;
   logic [20:0]                        recip_prod;
   logic [cdtd_pkg::YEAR_W-1:0]        quot_x400;
   logic                               leap;
   cdtd_pkg::month_type                doy_month;
   cdtd_pkg::day_type                  doy_day;
   logic [cdtd_pkg::DOY_W-1:0]         doy;
   logic signed [cdtd_pkg::DAYS_W-1:0] add_op;
   logic signed [cdtd_pkg::DAYS_W-1:0] add_sum;
   logic signed [cdtd_pkg::SECS_W-1:0] mul_full;
   logic signed [cdtd_pkg::SOD_W:0]    sod_diff;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.day_difference    = rsp_days_ff;
   assign rsp_if.second_difference = rsp_secs_ff;
   assign rsp_if.invalid           = rsp_bad_ff;

   assign bad_now = (m1_ff < 4'd1) || (m1_ff > 4'd12) || (d1_ff == 5'd0) ||
                    (y1_ff > cdtd_pkg::YEAR_LIMIT) ||
                    (m2_ff < 4'd1) || (m2_ff > 4'd12) || (d2_ff == 5'd0) ||
                    (y2_ff > cdtd_pkg::YEAR_LIMIT);
   // month and day fit their fixed-width fields, so the key compare is lexicographic
   assign swap = {y1_ff, m1_ff, d1_ff} > {y2_ff, m2_ff, d2_ff};

   // year / 400 as (year / 16) / 25
   assign recip_prod = 21'(year_ff[13:4]) * 21'(cdtd_pkg::RECIP_25);
   assign quot_x400  = (14'(quot_ff) << 8) + (14'(quot_ff) << 7) + (14'(quot_ff) << 4);

   // shared adder: one operand per sequencer step
   assign leap      = cdtd_pkg::leap_of(mod_ff);
   assign doy_month = (state_ff == S_DOYB) ? mb_ff : ma_ff;
   assign doy_day   = (state_ff == S_DOYB) ? db_ff : da_ff;
   assign doy       = cdtd_pkg::day_of_year(doy_month, doy_day, leap);

   always_comb begin
      unique case (state_ff)
         S_DOYA:  add_op = -$signed(cdtd_pkg::DAYS_W'(doy));
         S_YEARS: add_op = $signed(cdtd_pkg::DAYS_W'(leap ? cdtd_pkg::DAYS_LEAP
                                                           : cdtd_pkg::DAYS_COMMON));
         S_DOYB:  add_op = $signed(cdtd_pkg::DAYS_W'(doy));
         default: add_op = '0;
      endcase
   end
   assign add_sum = acc_ff + add_op;

   assign mul_full = cdtd_pkg::SECS_W'(acc_ff) * cdtd_pkg::SECS_W'(cdtd_pkg::SECONDS_PER_DAY);
   assign sod_diff = $signed({1'b0, s2_ff}) - $signed({1'b0, s1_ff});

   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      yb_in        = yb_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      neg_in       = neg_ff;
      bad_in       = bad_ff;
      quot_in      = quot_ff;
      mod_in       = mod_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_days_in  = rsp_days_ff;
      rsp_secs_in  = rsp_secs_ff;
      rsp_bad_in   = rsp_bad_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            bad_in = bad_now;
            neg_in = swap;
            acc_in = '0;
            if (swap) begin
               year_in = y2_ff;
               ma_in   = m2_ff;
               da_in   = d2_ff;
               yb_in   = y1_ff;
               mb_in   = m1_ff;
               db_in   = d1_ff;
            end else begin
               year_in = y1_ff;
               ma_in   = m1_ff;
               da_in   = d1_ff;
               yb_in   = y2_ff;
               mb_in   = m2_ff;
               db_in   = d2_ff;
            end
            state_in = bad_now ? S_FINISH : S_QUOT;
         end
         S_QUOT: begin
            quot_in  = recip_prod[20:15];
            state_in = S_MOD;
         end
         S_MOD: begin
            mod_in   = cdtd_pkg::MOD400_W'(year_ff - quot_x400);
            state_in = S_DOYA;
         end
         S_DOYA: begin
            acc_in   = add_sum;
            state_in = S_YEARS;
         end
         S_YEARS: begin
            if (year_ff < yb_ff) begin
               acc_in  = add_sum;
               year_in = year_ff + 14'd1;
               mod_in  = (mod_ff == cdtd_pkg::CYCLE_LAST) ? '0 : mod_ff + 9'd1;
            end else begin
               state_in = S_DOYB;
            end
         end
         S_DOYB: begin
            acc_in   = add_sum;
            state_in = S_NEG;
         end
         S_NEG: begin
            if (neg_ff) begin
               acc_in = -acc_ff;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = mul_full;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in   = bad_ff;
               if (bad_ff) begin
                  rsp_days_in = '0;
                  rsp_secs_in = '0;
               end else begin
                  rsp_days_in = acc_ff;
                  rsp_secs_in = prod_ff + cdtd_pkg::SECS_W'(sod_diff);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         y1_ff <= req_if.first_year;
         m1_ff <= req_if.first_month;
         d1_ff <= req_if.first_day;
         s1_ff <= req_if.first_second_of_day;
         y2_ff <= req_if.second_year;
         m2_ff <= req_if.second_month;
         d2_ff <= req_if.second_day;
         s2_ff <= req_if.second_second_of_day;
      end
      year_ff     <= year_in;
      yb_ff       <= yb_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      neg_ff      <= neg_in;
      bad_ff      <= bad_in;
      quot_ff     <= quot_in;
      mod_ff      <= mod_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_days_ff <= rsp_days_in;
      rsp_secs_ff <= rsp_secs_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   `CDTD_ASSERT(a_accept_to_check, clock, reset, accept |=> state_ff == S_CHECK, "request not taken into check")
   `CDTD_ASSERT(a_year_step, clock, reset, (state_ff == S_YEARS) && (year_ff < yb_ff) |=> year_ff == $past(year_ff) + 14'd1, "year counter did not advance")
   `CDTD_ASSERT(a_cycle_range, clock, reset, (state_ff == S_YEARS) || (state_ff == S_DOYB) |-> mod_ff <= cdtd_pkg::CYCLE_LAST, "year cycle position out of range")
   `CDTD_ASSERT(a_invalid_zero, clock, reset, rsp_valid_ff && rsp_bad_ff |-> (rsp_days_ff == '0) && (rsp_secs_ff == '0), "invalid result carries nonzero differences")
   `CDTD_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (state_ff == S_IDLE) && !rsp_valid_ff, "reset did not idle the block")

endmodule
